FILE: hdl/segp_pkg.sv
// Package for the sensor exposure and gain programmer.
// Shared widths, constants, register addresses, enums and beat structs.
// Depends on nothing.
`default_nettype none

package segp_pkg;

  localparam int unsigned UsW      = 23;
  localparam int unsigned GainW    = 24;
  localparam int unsigned NsW      = 16;
  localparam int unsigned RtcW     = 12;
  localparam int unsigned LinesW   = 16;
  localparam int unsigned ClkW     = 12;
  localparam int unsigned VrefhW   = 7;
  localparam int unsigned DW       = 10;
  localparam int unsigned DgW      = 18;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW    = NsW + RtcW;
  localparam int unsigned DivNumW  = 32;
  localparam int unsigned DivDenW  = 24;
  localparam int unsigned DivCntW  = 6;

  localparam int unsigned QueueDepth = 2;

  // exposure path
  localparam logic [UsW-1:0]     ExpUsMax = UsW'(4294967);
  localparam logic [9:0]         ScaleNs  = 10'd1000;
  localparam logic [DivCntW-1:0] ItLines  = DivCntW'(DivNumW);
  localparam logic [DivCntW-1:0] ItClk    = DivCntW'(ClkW);

  // gain path: vrefh = GainRef / gain, quotient fits in GainIt bits
  localparam int unsigned         GainRef     = 131072;
  localparam int unsigned         GainIt      = 8;
  localparam logic [DivCntW-1:0]  ItGain      = DivCntW'(GainIt);
  localparam logic [DivDenW-1:0]  GainRemInit = DivDenW'(GainRef >> GainIt);
  localparam logic [GainW-1:0]    GainMin     = GainW'(1024);
  localparam logic [GainIt-1:0]   VrefhHi     = 8'h7f;
  localparam logic [GainIt-1:0]   VrefhLo     = 8'h0c;
  localparam logic [GainW-1:0]    G2Min       = GainW'(1024);
  localparam logic [GainW-3:0]    DgainCap    = (GainW-2)'(256 * 3);

  // register reset values
  localparam logic [NsW-1:0]      RstRowNs    = 16'd43010;
  localparam logic [RtcW-1:0]     RstRowClk   = 12'd3096;
  localparam logic [LinesW-1:0]   RstVblank   = 16'd202;
  localparam logic [LinesW-1:0]   RstMaxLines = 16'd930;
  localparam logic [CfgDataW-1:0] RstMinDgain = 16'd307;

  // sensor register map
  localparam logic [ByteW-1:0] AddrVbHi    = 8'h21;
  localparam logic [ByteW-1:0] AddrVbLo    = 8'h22;
  localparam logic [ByteW-1:0] AddrLnHi    = 8'h0c;
  localparam logic [ByteW-1:0] AddrLnLo    = 8'h0d;
  localparam logic [ByteW-1:0] AddrCkHi    = 8'h26;
  localparam logic [ByteW-1:0] AddrCkLo    = 8'h27;
  localparam logic [ByteW-1:0] AddrRestart = 8'h1d;
  localparam logic [ByteW-1:0] AddrVrefh   = 8'hb1;
  localparam logic [ByteW-1:0] AddrDgHi    = 8'hb7;
  localparam logic [ByteW-1:0] AddrDgLo    = 8'hb8;
  localparam logic [ByteW-1:0] RestartData = 8'h02;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowNs    = 3'd0,
    CfgRowClk   = 3'd1,
    CfgVblank   = 3'd2,
    CfgMaxLines = 3'd3,
    CfgMinDgain = 3'd4
  } segp_cfg_idx_e;

  typedef enum logic [3:0] {
    FsIdle,
    FsScale,
    FsLineGo,
    FsLineWait,
    FsClass,
    FsClkGo,
    FsClkWait,
    FsGainGo,
    FsGainWait,
    FsGainMul,
    FsDgMul,
    FsPush
  } segp_fstate_e;

  typedef enum logic [1:0] {
    ClkRow,
    ClkZero,
    ClkDiv
  } segp_clkm_e;

  typedef enum logic [3:0] {
    StVbHi,
    StVbLo,
    StLnHi,
    StLnLo,
    StCkHi,
    StCkLo,
    StRestart,
    StVrefh,
    StDgHi,
    StDgLo
  } segp_step_e;

  typedef struct packed {
    logic [UsW-1:0]   exposure_us;
    logic [GainW-1:0] gain_q10;
  } segp_in_t;

  typedef struct packed {
    logic [ByteW-1:0]  reg_addr;
    logic [ByteW-1:0]  reg_data;
    logic [LinesW-1:0] exp_lines;
    logic [ClkW-1:0]   exp_clocks;
    logic              last;
  } segp_out_t;

  typedef struct packed {
    logic [NsW-1:0]      row_ns;
    logic [RtcW-1:0]     row_time_clocks;
    logic [LinesW-1:0]   vblank_lines;
    logic [LinesW-1:0]   max_exp_lines;
    logic [CfgDataW-1:0] min_digital_gain;
  } segp_cfg_t;

  typedef struct packed {
    logic               start;
    logic [DivDenW-1:0] rem_init;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
    logic [DivCntW-1:0] iters;
  } segp_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quo;
    logic [DivDenW-1:0] rem;
  } segp_div_rsp_t;

  typedef struct packed {
    logic [LinesW-1:0] vblank;
    logic [LinesW-1:0] lines;
    logic [ClkW-1:0]   clocks;
    logic [VrefhW-1:0] vrefh;
    logic [DgW-1:0]    dgain;
    logic              vb_chg;
    logic              ln_chg;
    logic              ck_chg;
    logic              dg_chg;
  } segp_job_t;

  typedef struct packed {
    logic       more;
    segp_step_e step;
  } segp_nxt_t;

endpackage

`default_nettype wire

FILE: hdl/segp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Caller supplies the partial remainder to start from and the bit count.
// Depends on segp_pkg.
`default_nettype none

module segp_div (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  segp_pkg::segp_div_req_t req_i,
  output segp_pkg::segp_div_rsp_t rsp_o
);

  logic [segp_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         done_q;
  logic [segp_pkg::DivDenW-1:0] rem_q, den_q;
  logic [segp_pkg::DivNumW-1:0] num_q, quo_q;
  logic [segp_pkg::DivDenW:0]   trial, diff;
  logic                         ge;

  always_comb begin
    trial = {rem_q, num_q[segp_pkg::DivNumW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    cnt_d = cnt_q;
    if (req_i.start) begin
      cnt_d = req_i.iters;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - segp_pkg::DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= !req_i.start && (cnt_q == segp_pkg::DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem_init;
      num_q <= req_i.num;
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[segp_pkg::DivDenW-1:0] : trial[segp_pkg::DivDenW-1:0];
      num_q <= {num_q[segp_pkg::DivNumW-2:0], 1'b0};
      quo_q <= {quo_q[segp_pkg::DivNumW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

FILE: hdl/segp_front.sv
// Front end: accepts an update, works out lines, clocks, vrefh and digital
// gain on a shared divider, flags what changed and queues the job.
// Depends on segp_pkg and segp_div.
`default_nettype none

module segp_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  segp_pkg::segp_cfg_t  cfg_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  segp_pkg::segp_in_t   in_data_i,
  output logic                 push_o,
  output segp_pkg::segp_job_t  push_data_o,
  input  wire                  full_i
);

  segp_pkg::segp_fstate_e state_q, state_d;
  segp_pkg::segp_div_req_t div_req;
  segp_pkg::segp_div_rsp_t div_rsp;

  logic [segp_pkg::UsW-1:0]          us_q;
  logic [segp_pkg::GainW-1:0]        gain_q;
  logic [segp_pkg::DivNumW-1:0]      ns_q;
  logic [segp_pkg::LinesW-1:0]       lines_q;
  segp_pkg::segp_clkm_e              clkm_q;
  logic [segp_pkg::ProdW-1:0]        prod_q;
  logic [segp_pkg::ClkW-1:0]         clocks_q;
  logic [segp_pkg::VrefhW-1:0]       vrefh_q;
  logic [segp_pkg::GainW+segp_pkg::VrefhW-1:0] gv_q;
  logic [segp_pkg::DW+segp_pkg::CfgDataW-1:0]  dm_q;

  logic [segp_pkg::LinesW-1:0] prev_vblank_q;
  logic [segp_pkg::LinesW-1:0] prev_lines_q;
  logic [segp_pkg::ClkW-1:0]   prev_clocks_q;
  logic [segp_pkg::DgW-1:0]    prev_dgain_q;

  logic [segp_pkg::NsW-1:0]              rns;
  logic [segp_pkg::UsW+9:0]              ns_full;
  logic [segp_pkg::ProdW-1:0]            prod_full;
  logic [segp_pkg::DivNumW-1:0]          max32;
  logic [segp_pkg::GainIt-1:0]           vq;
  logic [segp_pkg::GainW+segp_pkg::VrefhW-1:0] gv_full;
  logic [segp_pkg::GainW-1:0]            g2;
  logic [segp_pkg::GainW-3:0]            d_wide;
  logic [segp_pkg::DW-1:0]               d;
  logic [segp_pkg::DW+segp_pkg::CfgDataW-1:0] dm_full;
  logic [segp_pkg::DgW-1:0]              dgain;

  segp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    rns       = (cfg_i.row_ns == '0) ? segp_pkg::NsW'(1) : cfg_i.row_ns;
    ns_full   = us_q * segp_pkg::ScaleNs;
    prod_full = div_rsp.rem[segp_pkg::NsW-1:0] * cfg_i.row_time_clocks;
    max32     = segp_pkg::DivNumW'(cfg_i.max_exp_lines);
    vq        = div_rsp.quo[segp_pkg::GainIt-1:0];
    gv_full   = gain_q * vrefh_q;
    g2        = gv_q[segp_pkg::GainW+segp_pkg::VrefhW-1:segp_pkg::VrefhW];
    if (g2 < segp_pkg::G2Min) begin
      g2 = segp_pkg::G2Min;
    end
    d_wide    = g2[segp_pkg::GainW-1:2];
    d         = (d_wide > segp_pkg::DgainCap) ? segp_pkg::DgainCap[segp_pkg::DW-1:0]
                                               : d_wide[segp_pkg::DW-1:0];
    dm_full   = d * cfg_i.min_digital_gain;
    dgain     = dm_q[segp_pkg::DW+segp_pkg::CfgDataW-1:8];
  end

  always_comb begin
    state_d          = state_q;
    in_stall_o       = 1'b1;
    push_o           = 1'b0;
    div_req.start    = 1'b0;
    div_req.rem_init = '0;
    div_req.num      = ns_q;
    div_req.den      = segp_pkg::DivDenW'(rns);
    div_req.iters    = segp_pkg::ItLines;
    unique case (state_q)
      segp_pkg::FsIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = segp_pkg::FsScale;
        end
      end
      segp_pkg::FsScale:  state_d = segp_pkg::FsLineGo;
      segp_pkg::FsLineGo: begin
        div_req.start = 1'b1;
        state_d       = segp_pkg::FsLineWait;
      end
      segp_pkg::FsLineWait: begin
        if (div_rsp.done) begin
          state_d = segp_pkg::FsClass;
        end
      end
      segp_pkg::FsClass: state_d = segp_pkg::FsClkGo;
      segp_pkg::FsClkGo: begin
        div_req.start    = 1'b1;
        div_req.rem_init = segp_pkg::DivDenW'(prod_q[segp_pkg::ProdW-1:segp_pkg::ClkW]);
        div_req.num      = {prod_q[segp_pkg::ClkW-1:0],
                            {(segp_pkg::DivNumW-segp_pkg::ClkW){1'b0}}};
        div_req.iters    = segp_pkg::ItClk;
        state_d          = segp_pkg::FsClkWait;
      end
      segp_pkg::FsClkWait: begin
        if (div_rsp.done) begin
          state_d = segp_pkg::FsGainGo;
        end
      end
      segp_pkg::FsGainGo: begin
        div_req.start    = 1'b1;
        div_req.rem_init = segp_pkg::GainRemInit;
        div_req.num      = '0;
        div_req.den      = gain_q;
        div_req.iters    = segp_pkg::ItGain;
        state_d          = segp_pkg::FsGainWait;
      end
      segp_pkg::FsGainWait: begin
        if (div_rsp.done) begin
          state_d = segp_pkg::FsGainMul;
        end
      end
      segp_pkg::FsGainMul: state_d = segp_pkg::FsDgMul;
      segp_pkg::FsDgMul:   state_d = segp_pkg::FsPush;
      segp_pkg::FsPush: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = segp_pkg::FsIdle;
        end
      end
      default: state_d = segp_pkg::FsIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= segp_pkg::FsIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_vblank_q <= '0;
      prev_lines_q  <= '0;
      prev_clocks_q <= '0;
      prev_dgain_q  <= '1;
    end else if (push_o) begin
      prev_vblank_q <= cfg_i.vblank_lines;
      prev_lines_q  <= lines_q;
      prev_clocks_q <= clocks_q;
      prev_dgain_q  <= dgain;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == segp_pkg::FsIdle && in_valid_i) begin
      us_q   <= (in_data_i.exposure_us > segp_pkg::ExpUsMax) ? segp_pkg::ExpUsMax
                                                             : in_data_i.exposure_us;
      gain_q <= (in_data_i.gain_q10 < segp_pkg::GainMin) ? segp_pkg::GainMin
                                                         : in_data_i.gain_q10;
    end
    if (state_q == segp_pkg::FsScale) begin
      ns_q <= ns_full[segp_pkg::DivNumW-1:0];
    end
    if (state_q == segp_pkg::FsClass) begin
      prod_q <= prod_full;
      if (div_rsp.quo > max32) begin
        lines_q <= cfg_i.max_exp_lines;
        clkm_q  <= segp_pkg::ClkRow;
      end else if (div_rsp.quo == max32) begin
        lines_q <= cfg_i.max_exp_lines;
        clkm_q  <= segp_pkg::ClkDiv;
      end else if (div_rsp.quo == '0) begin
        lines_q <= segp_pkg::LinesW'(1);
        clkm_q  <= segp_pkg::ClkZero;
      end else begin
        lines_q <= div_rsp.quo[segp_pkg::LinesW-1:0];
        clkm_q  <= segp_pkg::ClkDiv;
      end
    end
    if (state_q == segp_pkg::FsClkWait && div_rsp.done) begin
      unique case (clkm_q)
        segp_pkg::ClkRow:  clocks_q <= cfg_i.row_time_clocks;
        segp_pkg::ClkZero: clocks_q <= '0;
        segp_pkg::ClkDiv:  clocks_q <= div_rsp.quo[segp_pkg::ClkW-1:0];
        default:           clocks_q <= '0;
      endcase
    end
    if (state_q == segp_pkg::FsGainWait && div_rsp.done) begin
      if (vq > segp_pkg::VrefhHi) begin
        vrefh_q <= segp_pkg::VrefhHi[segp_pkg::VrefhW-1:0];
      end else if (vq < segp_pkg::VrefhLo) begin
        vrefh_q <= segp_pkg::VrefhLo[segp_pkg::VrefhW-1:0];
      end else begin
        vrefh_q <= vq[segp_pkg::VrefhW-1:0];
      end
    end
    if (state_q == segp_pkg::FsGainMul) begin
      gv_q <= gv_full;
    end
    if (state_q == segp_pkg::FsDgMul) begin
      dm_q <= dm_full;
    end
  end

  always_comb begin
    push_data_o.vblank = cfg_i.vblank_lines;
    push_data_o.lines  = lines_q;
    push_data_o.clocks = clocks_q;
    push_data_o.vrefh  = vrefh_q;
    push_data_o.dgain  = dgain;
    push_data_o.vb_chg = cfg_i.vblank_lines != prev_vblank_q;
    push_data_o.ln_chg = lines_q != prev_lines_q;
    push_data_o.ck_chg = clocks_q != prev_clocks_q;
    push_data_o.dg_chg = dgain != prev_dgain_q;
  end

endmodule

`default_nettype wire

FILE: hdl/segp_fifo.sv
// Short job queue between the front end and the write sequencer.
// Depth from segp_pkg::QueueDepth, flop storage.
// Depends on segp_pkg.
`default_nettype none

module segp_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  segp_pkg::segp_job_t  push_data_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output segp_pkg::segp_job_t  pop_data_o,
  output logic                 empty_o
);

  localparam int unsigned PtrW = (segp_pkg::QueueDepth > 1) ?
                                 $clog2(segp_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(segp_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(segp_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(segp_pkg::QueueDepth);

  segp_pkg::segp_job_t entries_q [segp_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = count_q == CntFull;
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/segp_back.sv
// Write sequencer: takes one job from the queue and emits its sensor
// register writes through an output register, one beat per cycle while not stalled.
// Depends on segp_pkg.
`default_nettype none

module segp_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  empty_i,
  output logic                 pop_o,
  input  segp_pkg::segp_job_t  job_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output segp_pkg::segp_out_t  out_data_o
);

  logic                busy_q, out_valid_q, load_out;
  segp_pkg::segp_step_e step_q, first_step;
  segp_pkg::segp_job_t job_q;
  segp_pkg::segp_out_t out_q;
  segp_pkg::segp_nxt_t nxt;
  logic [segp_pkg::ByteW-1:0] addr, data;

  always_comb begin
    priority if (job_i.vb_chg) begin
      first_step = segp_pkg::StVbHi;
    end else if (job_i.ln_chg) begin
      first_step = segp_pkg::StLnHi;
    end else if (job_i.ck_chg) begin
      first_step = segp_pkg::StCkHi;
    end else begin
      first_step = segp_pkg::StRestart;
    end
  end

  always_comb begin
    nxt.more = 1'b1;
    nxt.step = segp_pkg::StRestart;
    addr     = segp_pkg::AddrRestart;
    data     = segp_pkg::RestartData;
    unique case (step_q)
      segp_pkg::StVbHi: begin
        addr     = segp_pkg::AddrVbHi;
        data     = job_q.vblank[15:8];
        nxt.step = segp_pkg::StVbLo;
      end
      segp_pkg::StVbLo: begin
        addr     = segp_pkg::AddrVbLo;
        data     = job_q.vblank[7:0];
        nxt.step = job_q.ln_chg ? segp_pkg::StLnHi :
                   job_q.ck_chg ? segp_pkg::StCkHi : segp_pkg::StRestart;
      end
      segp_pkg::StLnHi: begin
        addr     = segp_pkg::AddrLnHi;
        data     = job_q.lines[15:8];
        nxt.step = segp_pkg::StLnLo;
      end
      segp_pkg::StLnLo: begin
        addr     = segp_pkg::AddrLnLo;
        data     = job_q.lines[7:0];
        nxt.step = job_q.ck_chg ? segp_pkg::StCkHi : segp_pkg::StRestart;
      end
      segp_pkg::StCkHi: begin
        addr     = segp_pkg::AddrCkHi;
        data     = segp_pkg::ByteW'(job_q.clocks[segp_pkg::ClkW-1:8]);
        nxt.step = segp_pkg::StCkLo;
      end
      segp_pkg::StCkLo: begin
        addr     = segp_pkg::AddrCkLo;
        data     = job_q.clocks[7:0];
        nxt.step = segp_pkg::StRestart;
      end
      segp_pkg::StRestart: begin
        nxt.step = segp_pkg::StVrefh;
      end
      segp_pkg::StVrefh: begin
        addr     = segp_pkg::AddrVrefh;
        data     = segp_pkg::ByteW'(job_q.vrefh);
        nxt.more = job_q.dg_chg;
        nxt.step = segp_pkg::StDgHi;
      end
      segp_pkg::StDgHi: begin
        addr     = segp_pkg::AddrDgHi;
        data     = job_q.dgain[15:8];
        nxt.step = segp_pkg::StDgLo;
      end
      segp_pkg::StDgLo: begin
        addr     = segp_pkg::AddrDgLo;
        data     = job_q.dgain[7:0];
        nxt.more = 1'b0;
      end
      default: nxt.more = 1'b0;
    endcase
  end

  assign load_out = busy_q && (!out_valid_q || !out_stall_i);
  assign pop_o    = !busy_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= segp_pkg::StRestart;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        step_q <= first_step;
      end else if (load_out) begin
        if (nxt.more) begin
          step_q <= nxt.step;
        end else begin
          busy_q <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (load_out) begin
      out_q.reg_addr   <= addr;
      out_q.reg_data   <= data;
      out_q.exp_lines  <= job_q.lines;
      out_q.exp_clocks <= job_q.clocks;
      out_q.last       <= !nxt.more;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: hdl/sensor_exposure_gain_programmer.sv
// Top level of the sensor exposure and gain programmer: config registers,
// front end, job queue and write sequencer. Depends on segp_pkg and submodules.
// In the front end an update runs a 32-step line division,
// a 12-step clock division and an 8-step vrefh division on one shared divider.
// Write beats then follow via the queue, one per cycle unless stalled (2..10 per update).
// Reset is asynchronous, active low: config and control registers take their defaults at once.
`default_nettype none

module sensor_exposure_gain_programmer (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  segp_pkg::segp_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output segp_pkg::segp_out_t                  out_data_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [segp_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  wire [segp_pkg::CfgDataW-1:0]         cfg_data_i
);

  segp_pkg::segp_cfg_t cfg_q;
  segp_pkg::segp_job_t push_data, pop_data;
  logic push, full, pop, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_ns           <= segp_pkg::RstRowNs;
      cfg_q.row_time_clocks  <= segp_pkg::RstRowClk;
      cfg_q.vblank_lines     <= segp_pkg::RstVblank;
      cfg_q.max_exp_lines    <= segp_pkg::RstMaxLines;
      cfg_q.min_digital_gain <= segp_pkg::RstMinDgain;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        segp_pkg::CfgRowNs:    cfg_q.row_ns           <= cfg_data_i;
        segp_pkg::CfgRowClk:   cfg_q.row_time_clocks  <= cfg_data_i[segp_pkg::RtcW-1:0];
        segp_pkg::CfgVblank:   cfg_q.vblank_lines     <= cfg_data_i;
        segp_pkg::CfgMaxLines: cfg_q.max_exp_lines    <= cfg_data_i;
        segp_pkg::CfgMinDgain: cfg_q.min_digital_gain <= cfg_data_i;
        default: ;
      endcase
    end
  end

  segp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  segp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  segp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .job_i       (pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
